// File: rtl/ps2_device_frame_transmitter_macros.svh
// ----------------------------------------------------------------------------
// PS/2 device frame transmitter assertion macros
// Shared concurrent assertion forms for the transmitter's checker.
// ----------------------------------------------------------------------------
`ifndef PS2_DEVICE_FRAME_TRANSMITTER_MACROS_SVH
`define PS2_DEVICE_FRAME_TRANSMITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PS2DFT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PS2DFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// File: rtl/ps2dft_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 device frame transmitter package
// Shared constants, field positions and interface structs.
// ----------------------------------------------------------------------------
package ps2dft_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   // Request item field positions.
   localparam int REQ_CLK_BIT   = 0;
   localparam int REQ_DAT_BIT   = 1;
   localparam int REQ_PUSH_BIT  = 2;
   localparam int REQ_CODE_LSB  = 3;
   localparam int REQ_WAIT_LSB  = 11;

   // Response item field positions.
   localparam int RSP_CLK_BIT    = 0;
   localparam int RSP_DAT_BIT    = 1;
   localparam int RSP_SEND_BIT   = 2;
   localparam int RSP_PDROP_BIT  = 3;
   localparam int RSP_FDROP_BIT  = 4;
   localparam int RSP_COUNT_LSB  = 5;
   localparam int RSP_COUNT_W    = 5;

   typedef enum logic [1:0] {
      CSR_HALF_BIT   = 2'd0,
      CSR_CLOCK_LOW  = 2'd1,
      CSR_IDLE_HOLD  = 2'd2,
      CSR_WAIT_STEP  = 2'd3
   } csr_index_type;

   localparam logic [9:0]  HALF_BIT_RESET   = 10'd20;
   localparam logic [9:0]  CLOCK_LOW_RESET  = 10'd40;
   localparam logic [9:0]  IDLE_HOLD_RESET  = 10'd50;
   localparam logic [15:0] WAIT_STEP_RESET  = 16'd10000;

   localparam logic [7:0] CODE_EXTENDED = 8'hE0;
   localparam logic [7:0] CODE_BREAK    = 8'hF0;
   localparam logic [3:0] FRAME_BITS    = 4'd11;

   typedef struct packed {
      logic [9:0]  half_bit_ticks;
      logic [9:0]  clock_low_ticks;
      logic [9:0]  idle_hold_ticks;
      logic [15:0] ticks_per_wait_step;
   } cfg_type;

   typedef struct packed {
      logic       has_entry;
      logic [7:0] code;
      logic [7:0] steps;
   } head_type;

   typedef struct packed {
      logic clk_drive_low;
      logic dat_drive_low;
      logic sending;
      logic frame_dropped;
   } eng_out_type;

endpackage

// File: rtl/ps2dft_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ps2dft_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ps2dft_queue.sv
// ----------------------------------------------------------------------------
// PS/2 transmitter scancode queue
// FIFO of scancodes with hold steps; shows the head after this tick's push.
// ----------------------------------------------------------------------------
module ps2dft_queue
   import ps2dft_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        push_valid,
   input  logic [7:0]  push_code,
   input  logic [11:0] push_wait_ms,
   input  logic        pop,
   output head_type    head,
   output logic        push_dropped,
   output logic [RSP_COUNT_W-1:0] queue_count
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   // 6554 / 65536 approximates 1/10 closely enough for 13-bit operands.
   localparam logic [12:0] RECIP_TEN = 13'd6554;

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_mid;
   logic             fwd_valid_ff, fwd_valid_in;
   logic [15:0]      fwd_data_ff;
   logic [15:0]      ram_q;
   logic [15:0]      wr_data;
   logic             push_ok;
   logic             wr_en;
   logic             pop_ok;
   logic [12:0]      ms_round;
   logic [25:0]      quot_prod;
   logic [9:0]       quot;
   logic [7:0]       steps;
   logic [15:0]      head_word;

   // Hold steps are the wait rounded up to whole 10 ms steps, capped at 255.
   assign ms_round  = {1'b0, push_wait_ms} + 13'd9;
   assign quot_prod = ms_round * RECIP_TEN;
   assign quot      = quot_prod[25:16];
   assign steps     = (quot > 10'd255) ? 8'd255 : quot[7:0];

   assign push_ok      = push_valid && (cnt_ff != CNT_FULL);
   assign push_dropped = push_valid && (cnt_ff == CNT_FULL);
   assign cnt_mid      = cnt_ff + CNT_W'(push_ok);
   assign wr_data      = {steps, push_code};
   assign wr_en        = step && push_ok;
   assign pop_ok       = step && pop;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (step) begin
         cnt_in = cnt_mid - CNT_W'(pop);
      end
   end

   // The RAM returns old data when it is read and written at one address in
   // the same cycle, so that write data is forwarded from a register instead.
   assign fwd_valid_in = wr_en && (wr_ptr_ff == rd_ptr_in);

   always_comb begin
      if (cnt_ff == '0) begin
         head_word = wr_data;
      end else if (fwd_valid_ff) begin
         head_word = fwd_data_ff;
      end else begin
         head_word = ram_q;
      end
   end

   assign head.has_entry = (cnt_mid != '0);
   assign head.code      = head_word[7:0];
   assign head.steps     = head_word[15:8];
   assign queue_count    = RSP_COUNT_W'(cnt_in);

   ps2dft_ram #(
      .WIDTH (16),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_ptr_in),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         cnt_ff       <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         cnt_ff       <= cnt_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
   end

endmodule

// File: rtl/ps2dft_engine.sv
// ----------------------------------------------------------------------------
// PS/2 transmitter frame engine
// Sequences idle detect, frame bits, scancode chaining and hold time.
// ----------------------------------------------------------------------------
module ps2dft_engine
   import ps2dft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        clk_line,
   input  logic        dat_line,
   input  cfg_type     cfg,
   input  head_type    head,
   output logic        pop,
   output eng_out_type eng_out
);

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_SETUP = 6'b000010,
      PH_LOW   = 6'b000100,
      PH_HIGH  = 6'b001000,
      PH_HOLD  = 6'b010000,
      PH_AFTER = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic        parity_ff, parity_in;
   logic [15:0] timer_ff, timer_in;
   logic [7:0]  wait_ff, wait_in;
   logic [15:0] timer_inc;
   logic [7:0]  wait_dec;
   logic [3:0]  bit_sel;
   logic        finish;
   logic        start;
   logic        frame_dropped;
   logic        cur_bit;
   logic        in_frame;

   assign timer_inc = timer_ff + 16'd1;
   assign wait_dec  = (wait_ff != 8'd0) ? wait_ff - 8'd1 : wait_ff;

   always_comb begin
      phase_in      = phase_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      parity_in     = parity_ff;
      timer_in      = timer_ff;
      wait_in       = wait_ff;
      finish        = 1'b0;
      start         = 1'b0;
      frame_dropped = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (!head.has_entry || !clk_line) begin
               timer_in = '0;
            end else if (!((timer_ff == '0) && !dat_line)) begin
               // Counting only begins on a tick with both lines high.
               timer_in = timer_inc;
               if (timer_inc >= {6'd0, cfg.idle_hold_ticks}) begin
                  start = 1'b1;
               end
            end
         end
         PH_SETUP: begin
            if (timer_ff >= {6'd0, cfg.half_bit_ticks}) begin
               phase_in = PH_LOW;
               timer_in = 16'd1;
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_LOW: begin
            if (timer_ff >= {6'd0, cfg.clock_low_ticks}) begin
               phase_in = PH_HIGH;
               timer_in = 16'd1;
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_HIGH: begin
            if (timer_ff >= {6'd0, cfg.half_bit_ticks}) begin
               bit_in = bit_ff + 4'd1;
               if (bit_in >= FRAME_BITS) begin
                  finish = 1'b1;
               end else begin
                  phase_in = PH_SETUP;
                  timer_in = 16'd1;
               end
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_HOLD: begin
            if (timer_inc >= cfg.ticks_per_wait_step) begin
               timer_in = '0;
               wait_in  = wait_dec;
               if (wait_dec == 8'd0) begin
                  phase_in = PH_IDLE;
               end
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_AFTER: begin
            finish = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
            timer_in = '0;
         end
      endcase

      // End of a byte: prefix codes chain straight into the next queued byte,
      // or return to idle if none is queued; anything else waits out its hold steps.
      if (finish) begin
         if ((shift_ff == CODE_EXTENDED) || (shift_ff == CODE_BREAK)) begin
            if (head.has_entry) begin
               start = 1'b1;
            end else begin
               phase_in = PH_IDLE;
               timer_in = '0;
            end
         end else begin
            phase_in = (wait_ff == 8'd0) ? PH_IDLE : PH_HOLD;
            timer_in = '0;
         end
      end

      if (start) begin
         shift_in  = head.code;
         wait_in   = head.steps;
         parity_in = ~^head.code;
         if (clk_line && dat_line) begin
            phase_in = PH_SETUP;
            bit_in   = '0;
            timer_in = 16'd1;
         end else begin
            phase_in      = PH_AFTER;
            timer_in      = '0;
            frame_dropped = 1'b1;
         end
      end
   end

   assign pop = start;

   // Bit on the wire: start, eight data bits LSB first, parity, stop.
   assign bit_sel = bit_in - 4'd1;
   always_comb begin
      if (bit_in == 4'd0) begin
         cur_bit = 1'b0;
      end else if (bit_in <= 4'd8) begin
         cur_bit = shift_in[bit_sel[2:0]];
      end else if (bit_in == 4'd9) begin
         cur_bit = parity_in;
      end else begin
         cur_bit = 1'b1;
      end
   end

   assign in_frame = (phase_in == PH_SETUP) || (phase_in == PH_LOW) || (phase_in == PH_HIGH);

   assign eng_out.clk_drive_low = (phase_in == PH_LOW);
   assign eng_out.dat_drive_low = in_frame && !cur_bit;
   assign eng_out.sending       = (phase_in != PH_IDLE);
   assign eng_out.frame_dropped = frame_dropped;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         bit_ff    <= '0;
         shift_ff  <= '0;
         parity_ff <= 1'b1;
         timer_ff  <= '0;
         wait_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         parity_ff <= parity_in;
         timer_ff  <= timer_in;
         wait_ff   <= wait_in;
      end
   end

endmodule

// File: rtl/ps2_device_frame_transmitter.sv
// A request item waits in the input register until its result moves into the output register.
// Throughput: one item per cycle unless stalled; queue, engine and output run each tick.
// A stalled result is held while the input register still takes one more item.
// Reset is synchronous: queue empty, engine idle, timing registers back to their defaults.
// The scancode memory is not cleared; entries are only read after being written.
// ----------------------------------------------------------------------------
// PS/2 device frame transmitter
// Queues scancodes and sends them to the host as PS/2 device frames.
// ----------------------------------------------------------------------------
module ps2_device_frame_transmitter
   import ps2dft_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // clk_line, dat_line, push_valid, push_code[7:0], push_wait_ms[11:0], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // clk_drive_low, dat_drive_low, sending, push_dropped, frame_dropped,
   // queue_count[4:0], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data
);

   logic                   in_valid_ff, in_valid_in;
   logic [REQ_TDATA_W-1:0] in_data_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   cfg_type                cfg_ff;
   logic                   step;
   head_type               head;
   logic                   pop;
   eng_out_type            eng_out;
   logic                   push_dropped;
   logic [RSP_COUNT_W-1:0] queue_count;

   // An item moves into the output register whenever that register is free
   // or being emptied in the same cycle.
   assign step        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
   end

   ps2dft_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .push_valid   (in_data_ff[REQ_PUSH_BIT]),
      .push_code    (in_data_ff[REQ_CODE_LSB +: 8]),
      .push_wait_ms (in_data_ff[REQ_WAIT_LSB +: 12]),
      .pop          (pop),
      .head         (head),
      .push_dropped (push_dropped),
      .queue_count  (queue_count)
   );

   ps2dft_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .clk_line (in_data_ff[REQ_CLK_BIT]),
      .dat_line (in_data_ff[REQ_DAT_BIT]),
      .cfg      (cfg_ff),
      .head     (head),
      .pop      (pop),
      .eng_out  (eng_out)
   );

   always_comb begin
      out_data_in = '0;
      out_data_in[RSP_CLK_BIT]                   = eng_out.clk_drive_low;
      out_data_in[RSP_DAT_BIT]                   = eng_out.dat_drive_low;
      out_data_in[RSP_SEND_BIT]                  = eng_out.sending;
      out_data_in[RSP_PDROP_BIT]                 = push_dropped;
      out_data_in[RSP_FDROP_BIT]                 = eng_out.frame_dropped;
      out_data_in[RSP_COUNT_LSB +: RSP_COUNT_W]  = queue_count;
   end

   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                <= 1'b0;
         out_valid_ff               <= 1'b0;
         cfg_ff.half_bit_ticks      <= HALF_BIT_RESET;
         cfg_ff.clock_low_ticks     <= CLOCK_LOW_RESET;
         cfg_ff.idle_hold_ticks     <= IDLE_HOLD_RESET;
         cfg_ff.ticks_per_wait_step <= WAIT_STEP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_HALF_BIT:  cfg_ff.half_bit_ticks      <= csr_data[9:0];
               CSR_CLOCK_LOW: cfg_ff.clock_low_ticks     <= csr_data[9:0];
               CSR_IDLE_HOLD: cfg_ff.idle_hold_ticks     <= csr_data[9:0];
               CSR_WAIT_STEP: cfg_ff.ticks_per_wait_step <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

endmodule

// File: rtl/ps2dft_checker.sv
// ----------------------------------------------------------------------------
// PS/2 device frame transmitter checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "ps2_device_frame_transmitter_macros.svh"

module ps2dft_checker
   import ps2dft_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam logic [RSP_COUNT_W-1:0] MAX_COUNT =
      (QUEUE_DEPTH > 31) ? RSP_COUNT_W'(31) : RSP_COUNT_W'(QUEUE_DEPTH);

   logic                   clk_drv;
   logic                   dat_drv;
   logic                   sending;
   logic                   fdrop;
   logic [RSP_COUNT_W-1:0] count;

   assign clk_drv = rsp_tdata[RSP_CLK_BIT];
   assign dat_drv = rsp_tdata[RSP_DAT_BIT];
   assign sending = rsp_tdata[RSP_SEND_BIT];
   assign fdrop   = rsp_tdata[RSP_FDROP_BIT];
   assign count   = rsp_tdata[RSP_COUNT_LSB +: RSP_COUNT_W];

   // A result item that is not taken stays on the bus unchanged.
   `PS2DFT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Lines are only driven while a frame is under way.
   `PS2DFT_ASSERT_SAME(a_idle_released, clock, reset, rsp_tvalid && !sending, !clk_drv && !dat_drv)

   // A dropped frame leaves both lines released but the block still busy.
   `PS2DFT_ASSERT_SAME(a_drop_released, clock, reset, rsp_tvalid && fdrop, sending && !clk_drv && !dat_drv)

   // The queue never reports more entries than it holds.
   `PS2DFT_ASSERT_SAME(a_count_bound, clock, reset, rsp_tvalid, count <= MAX_COUNT)

endmodule

bind ps2_device_frame_transmitter ps2dft_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ps2dft_checker (.*);
